// ===== src/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants for the MIDI message encoder
// Opcodes, fixed MIDI byte values, field widths and the run record that
// travels from the front end to the byte serializer.
// ----------------------------------------------------------------------------
package mme_pkg;

  // field widths
  localparam int OPCODE_W = 3;
  localparam int CHAN_W   = 4;
  localparam int BYTE_W   = 8;
  localparam int BEND_W   = 14;
  localparam int DATA7_W  = 7;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  // longest run of bytes one command can cause
  localparam int RUN_MAX = 8;
  localparam int RUN_IDX_W = 3;

  // command opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_NOTE_OFF = 3'd0,
    OP_NOTE_ON  = 3'd1,
    OP_PROGRAM  = 3'd2,
    OP_CONTROL  = 3'd3,
    OP_BEND     = 3'd4,
    OP_SYSEX    = 3'd5
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_ID  = 1'b1;

  localparam logic [CFG_W-1:0] DEVICE_ID_RST = 7'h10;
  localparam logic [CFG_W-1:0] MODEL_ID_RST  = 7'h16;

  // status nibbles (upper half of the status byte)
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CONTROL  = 4'hB;
  localparam logic [3:0] ST_PROGRAM  = 4'hC;
  localparam logic [3:0] ST_BEND     = 4'hE;

  // sysex framing bytes
  localparam logic [BYTE_W-1:0] SX_START = 8'hF0;
  localparam logic [BYTE_W-1:0] SX_MAKER = 8'h41;
  localparam logic [BYTE_W-1:0] SX_DT1   = 8'h12;
  localparam logic [BYTE_W-1:0] SX_END   = 8'hF7;

  // number of header bytes ahead of the first payload byte
  localparam logic [RUN_IDX_W-1:0] SX_HDR_LEN = 3'd5;

  // one command's bytes, ready to serialize
  typedef struct packed {
    logic [RUN_MAX-1:0][BYTE_W-1:0] bytes;
    logic [RUN_IDX_W-1:0]           last_idx;
  } run_t;

  // front end to queue
  typedef struct packed {
    logic valid;
    run_t run;
  } push_t;

  // queue to serializer
  typedef struct packed {
    logic avail;
    run_t run;
  } head_t;

endpackage

// ===== src/mme_in_if.sv =====
// ----------------------------------------------------------------------------
// mme_in_if: command channel
// Valid/ready channel carrying one encoder command per transaction.
// ----------------------------------------------------------------------------
interface mme_in_if import mme_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAN_W-1:0]   channel;
  logic [BYTE_W-1:0]   data_one;
  logic [BYTE_W-1:0]   data_two;
  logic [BEND_W-1:0]   bend_value;
  logic                first;
  logic                last;

  modport source (
    output valid, opcode, channel, data_one, data_two, bend_value, first, last,
    input  ready
  );

  modport sink (
    input  valid, opcode, channel, data_one, data_two, bend_value, first, last,
    output ready
  );

endinterface

// ===== src/mme_out_if.sv =====
// ----------------------------------------------------------------------------
// mme_out_if: MIDI byte channel
// Valid/ready channel carrying one MIDI byte per transaction.
// ----------------------------------------------------------------------------
interface mme_out_if import mme_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              end_of_run;

  modport source (
    output valid, out_byte, end_of_run,
    input  ready
  );

  modport sink (
    input  valid, out_byte, end_of_run,
    output ready
  );

endinterface

// ===== src/mme_front.sv =====
// ----------------------------------------------------------------------------
// mme_front: command decode
// Accepts commands, builds the complete byte run for each one, keeps the
// sysex payload sum and holds the sysex header configuration registers.
// ----------------------------------------------------------------------------
module mme_front import mme_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  mme_in_if.sink               in_ch,
  input  logic                 q_full,
  output push_t                push,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0]     device_id_r;
  logic [CFG_W-1:0]     model_id_r;
  logic [DATA7_W-1:0]   sum_r;
  logic [DATA7_W-1:0]   sum_nxt;
  logic [DATA7_W-1:0]   sum_base;
  logic [DATA7_W-1:0]   checksum;
  logic [RUN_IDX_W-1:0] sx_base;
  logic                 accept;
  logic                 known_op;
  run_t                 run;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= DEVICE_ID_RST;
      model_id_r  <= MODEL_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ID: device_id_r <= cfg_wdata;
        CFG_MODEL_ID:  model_id_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // running payload sum, restarted by a first-marked byte
  assign sum_base = in_ch.first ? '0 : sum_r;
  assign sum_nxt  = DATA7_W'(sum_base + in_ch.data_one[DATA7_W-1:0]);
  assign checksum = DATA7_W'({DATA7_W{1'b0}} - sum_nxt);
  assign sx_base  = in_ch.first ? SX_HDR_LEN : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (accept && (op_t'(in_ch.opcode) == OP_SYSEX)) begin
      sum_r <= sum_nxt;
    end
  end

  // build the byte run
  always_comb begin
    run      = '0;
    known_op = 1'b1;
    case (op_t'(in_ch.opcode))
      OP_NOTE_OFF, OP_NOTE_ON, OP_CONTROL: begin
        case (op_t'(in_ch.opcode))
          OP_NOTE_OFF: run.bytes[0] = {ST_NOTE_OFF, in_ch.channel};
          OP_NOTE_ON:  run.bytes[0] = {ST_NOTE_ON, in_ch.channel};
          default:     run.bytes[0] = {ST_CONTROL, in_ch.channel};
        endcase
        run.bytes[1] = {1'b0, in_ch.data_one[DATA7_W-1:0]};
        run.bytes[2] = {1'b0, in_ch.data_two[DATA7_W-1:0]};
        run.last_idx = 3'd2;
      end
      OP_PROGRAM: begin
        run.bytes[0] = {ST_PROGRAM, in_ch.channel};
        run.bytes[1] = {1'b0, in_ch.data_one[DATA7_W-1:0]};
        run.last_idx = 3'd1;
      end
      OP_BEND: begin
        run.bytes[0] = {ST_BEND, in_ch.channel};
        run.bytes[1] = {1'b0, in_ch.bend_value[DATA7_W-1:0]};
        run.bytes[2] = {1'b0, in_ch.bend_value[BEND_W-1:DATA7_W]};
        run.last_idx = 3'd2;
      end
      OP_SYSEX: begin
        // header slots are overwritten by payload when there is no header
        run.bytes[0] = SX_START;
        run.bytes[1] = SX_MAKER;
        run.bytes[2] = {1'b0, device_id_r};
        run.bytes[3] = {1'b0, model_id_r};
        run.bytes[4] = SX_DT1;
        run.bytes[sx_base] = in_ch.data_one;
        if (in_ch.last) begin
          run.bytes[RUN_IDX_W'(sx_base + 3'd1)] = {1'b0, checksum};
          run.bytes[RUN_IDX_W'(sx_base + 3'd2)] = SX_END;
          run.last_idx = RUN_IDX_W'(sx_base + 3'd2);
        end else begin
          run.last_idx = sx_base;
        end
      end
      default: known_op = 1'b0;
    endcase
  end

  // undefined opcodes are consumed without producing a run
  assign push.valid = accept && known_op;
  assign push.run   = run;

endmodule

// ===== src/mme_queue.sv =====
// ----------------------------------------------------------------------------
// mme_queue: run queue
// Small FIFO of complete byte runs between the decoder and the serializer.
// ----------------------------------------------------------------------------
module mme_queue import mme_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  full,
  input  logic  pop,
  output head_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign do_pop = pop && (count_r != '0);

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr_r] <= push.run;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      case ({push.valid, do_pop})
        2'b10:   count_r <= CNT_W'(count_r + 1'b1);
        2'b01:   count_r <= CNT_W'(count_r - 1'b1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign head.avail = (count_r != '0);
  assign head.run   = mem[rd_ptr_r];

endmodule

// ===== src/mme_back.sv =====
// ----------------------------------------------------------------------------
// mme_back: byte serializer
// Walks the run at the queue head one byte per cycle, unless out_ch stalls,
// into a registered output stage, flagging the final byte of each run.
// ----------------------------------------------------------------------------
module mme_back import mme_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  head_t  head,
  output logic   pop,
  mme_out_if.source out_ch
);

  logic [RUN_IDX_W-1:0] idx_r;
  logic [RUN_IDX_W-1:0] idx_nxt;
  logic                 out_valid_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic                 out_end_r;
  logic                 load;
  logic                 at_end;

  // output stage can take a byte when empty or being drained
  assign load   = head.avail && (!out_valid_r || out_ch.ready);
  assign at_end = (idx_r == head.run.last_idx);
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = at_end ? '0 : RUN_IDX_W'(idx_r + 1'b1);
    end
  end

  // byte index within the head run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= head.run.bytes[idx_r];
      out_end_r  <= at_end;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.end_of_run = out_end_r;

endmodule

// ===== src/midi_message_encoder.sv =====
// ----------------------------------------------------------------------------
// midi_message_encoder: MIDI channel message and sysex byte encoder
// Converts commands into MIDI byte streams with a sysex checksum.
// ----------------------------------------------------------------------------
// Each command on in_ch becomes a run of MIDI bytes on out_ch, one byte per
// transaction, with end_of_run set on the run's final byte. Note off, note
// on, control change and pitch bend give 3 bytes, program change 2, a sysex
// payload byte 1, plus 5 header bytes when marked first and the checksum and
// F7 when marked last (up to 8). Undefined opcodes are taken and dropped.
// The serializer emits one byte per cycle unless out_ch stalls it; the
// decoder builds the whole run in the accepting cycle and parks it in a
// QUEUE_DEPTH-entry queue, so commands are accepted back to back while
// earlier runs are still being sent, until the queue is full. With an
// empty queue the first byte goes through the queue entry and then the
// output register. Configuration (device and model id of the sysex header)
// is taken on any cycle with cfg_we high and must be written while idle.
// ----------------------------------------------------------------------------
module midi_message_encoder import mme_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mme_in_if.sink               in_ch,
  mme_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  push_t push;
  head_t head;
  logic  q_full;
  logic  pop;

  // decode and run build
  mme_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // run queue
  mme_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  // byte serializer
  mme_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== sim/mme_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_stream_checker: byte stream scoreboard for the MIDI message encoder
// Watches the command and byte channels and the register port. It encodes
// every accepted command into the byte run it should cause and compares
// each byte the encoder sends against the oldest expected byte.
// ----------------------------------------------------------------------------
module mme_stream_checker import mme_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  mme_in_if                    cmd_mon,
  mme_out_if                   byte_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   bytes_pending,
  output int                   cmds_taken,
  output int                   bytes_checked,
  output int                   frames_closed
);

  typedef struct packed {
    logic [BYTE_W-1:0] octet;
    logic              run_end;
  } midi_byte_t;

  // bytes still owed by the encoder, oldest first
  midi_byte_t expected_bytes[$];

  // encoder state as seen from outside
  logic [CFG_W-1:0]   device_id_q;
  logic [CFG_W-1:0]   model_id_q;
  logic [DATA7_W-1:0] sysex_sum;

  int n_fail   = 0;
  int n_cmds   = 0;
  int n_bytes  = 0;
  int n_frames = 0;

  function automatic void flag_mismatch(input string msg);
    n_fail++;
    if (n_fail <= 10) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endfunction

  // turn one command into its MIDI bytes and queue them
  function automatic void encode_command(
    input logic [OPCODE_W-1:0] opcode,
    input logic [CHAN_W-1:0]   chan,
    input logic [BYTE_W-1:0]   d1,
    input logic [BYTE_W-1:0]   d2,
    input logic [BEND_W-1:0]   bend,
    input logic                first,
    input logic                last
  );
    logic [BYTE_W-1:0]  run_bytes[$];
    logic [3:0]         status_hi;
    logic [DATA7_W-1:0] chk;
    midi_byte_t         entry;

    case (opcode)
      OP_NOTE_OFF: status_hi = ST_NOTE_OFF;
      OP_NOTE_ON:  status_hi = ST_NOTE_ON;
      OP_CONTROL:  status_hi = ST_CONTROL;
      OP_PROGRAM:  status_hi = ST_PROGRAM;
      default:     status_hi = ST_BEND;
    endcase

    case (opcode)
      OP_NOTE_OFF, OP_NOTE_ON, OP_CONTROL: begin
        run_bytes.push_back({status_hi, chan});
        run_bytes.push_back({1'b0, d1[6:0]});
        run_bytes.push_back({1'b0, d2[6:0]});
      end
      OP_PROGRAM: begin
        run_bytes.push_back({status_hi, chan});
        run_bytes.push_back({1'b0, d1[6:0]});
      end
      OP_BEND: begin
        run_bytes.push_back({status_hi, chan});
        run_bytes.push_back({1'b0, bend[6:0]});
        run_bytes.push_back({1'b0, bend[13:7]});
      end
      OP_SYSEX: begin
        // header opens a new frame and restarts the checksum
        if (first) begin
          run_bytes.push_back(SX_START);
          run_bytes.push_back(SX_MAKER);
          run_bytes.push_back({1'b0, device_id_q});
          run_bytes.push_back({1'b0, model_id_q});
          run_bytes.push_back(SX_DT1);
          sysex_sum = '0;
        end
        // payload goes out raw, the sum keeps only 7 bits
        run_bytes.push_back(d1);
        sysex_sum = DATA7_W'(sysex_sum + d1[6:0]);
        if (last) begin
          chk = 7'd0 - sysex_sum;
          run_bytes.push_back({1'b0, chk});
          run_bytes.push_back(SX_END);
          n_frames++;
        end
      end
      default: begin
        // undefined opcode: no bytes, no state change
      end
    endcase

    foreach (run_bytes[i]) begin
      entry.octet   = run_bytes[i];
      entry.run_end = (i == run_bytes.size() - 1);
      expected_bytes.push_back(entry);
    end
  endfunction

  // one pass per clock: outgoing byte, register write, incoming command
  always @(posedge clk) begin : monitor
    midi_byte_t exp_b;
    if (!rst_n) begin
      expected_bytes.delete();
      device_id_q = DEVICE_ID_RST;
      model_id_q  = MODEL_ID_RST;
      sysex_sum   = '0;
    end else begin
      if (byte_mon.valid && byte_mon.ready) begin
        n_bytes++;
        if (expected_bytes.size() == 0) begin
          flag_mismatch($sformatf("byte %02h (end %0b) with nothing expected",
                                  byte_mon.out_byte, byte_mon.end_of_run));
        end else begin
          exp_b = expected_bytes.pop_front();
          if (byte_mon.out_byte !== exp_b.octet) begin
            flag_mismatch($sformatf("byte %0d out_byte expected %02h got %02h",
                                    n_bytes, exp_b.octet, byte_mon.out_byte));
          end
          if (byte_mon.end_of_run !== exp_b.run_end) begin
            flag_mismatch($sformatf("byte %0d end_of_run expected %0b got %0b",
                                    n_bytes, exp_b.run_end, byte_mon.end_of_run));
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_DEVICE_ID: device_id_q = cfg_wdata;
          CFG_MODEL_ID:  model_id_q  = cfg_wdata;
          default:       ;
        endcase
      end

      if (cmd_mon.valid && cmd_mon.ready) begin
        n_cmds++;
        encode_command(cmd_mon.opcode, cmd_mon.channel, cmd_mon.data_one,
                       cmd_mon.data_two, cmd_mon.bend_value, cmd_mon.first,
                       cmd_mon.last);
      end
    end

    fail_count    <= n_fail;
    bytes_pending <= expected_bytes.size();
    cmds_taken    <= n_cmds;
    bytes_checked <= n_bytes;
    frames_closed <= n_frames;
  end

endmodule

// ===== sim/tb_midi_message_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_message_encoder: testbench for the MIDI message encoder
// Drives directed corner commands, then random channel messages and sysex
// frames under four idling profiles and several header id settings. The
// stream checker predicts every byte; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_midi_message_encoder;
  import mme_pkg::*;

  // opcodes the encoder takes and drops
  localparam logic [OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;

  localparam int PHASE_CMDS   = 106;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int NUM_PHASES   = 4;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAN_W-1:0]   channel;
    logic [BYTE_W-1:0]   data_one;
    logic [BYTE_W-1:0]   data_two;
    logic [BEND_W-1:0]   bend_value;
    logic                first;
    logic                last;
  } midi_cmd_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int cmds_counted   = 0;

  int fail_count;
  int bytes_pending;
  int cmds_taken;
  int bytes_checked;
  int frames_closed;

  mme_in_if  in_ch ();
  mme_out_if out_ch ();

  midi_message_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mme_stream_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_mon       (in_ch),
    .byte_mon      (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .bytes_pending (bytes_pending),
    .cmds_taken    (cmds_taken),
    .bytes_checked (bytes_checked),
    .frames_closed (frames_closed)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // byte receiver with random backpressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding",
               cycle_count, bytes_pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic midi_cmd_t mk_cmd(
    input logic [OPCODE_W-1:0] op,
    input logic [CHAN_W-1:0]   ch,
    input logic [BYTE_W-1:0]   d1,
    input logic [BYTE_W-1:0]   d2,
    input logic [BEND_W-1:0]   bend,
    input logic                first,
    input logic                last
  );
    midi_cmd_t c;
    c.opcode     = op;
    c.channel    = ch;
    c.data_one   = d1;
    c.data_two   = d2;
    c.bend_value = bend;
    c.first      = first;
    c.last       = last;
    return c;
  endfunction

  // every field random except the opcode
  function automatic midi_cmd_t rand_cmd(input logic [OPCODE_W-1:0] op);
    return mk_cmd(op, CHAN_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                  BEND_W'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  // one command transaction, with random idle cycles ahead of it
  task automatic send_cmd(input midi_cmd_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= c.opcode;
    in_ch.channel    <= c.channel;
    in_ch.data_one   <= c.data_one;
    in_ch.data_two   <= c.data_two;
    in_ch.bend_value <= c.bend_value;
    in_ch.first      <= c.first;
    in_ch.last       <= c.last;
    do @(posedge clk); while (!in_ch.ready);
    if (c.opcode != OP_UNUSED_6 && c.opcode != OP_UNUSED_7) begin
      cmds_counted++;
    end
  endtask

  // well-formed sysex frame with random payload
  task automatic send_sysex_frame(input int len);
    midi_cmd_t c;
    for (int i = 0; i < len; i++) begin
      c       = rand_cmd(OP_SYSEX);
      c.first = (i == 0);
      c.last  = (i == len - 1);
      send_cmd(c);
    end
  endtask

  // stop sending and let the encoder run dry
  task automatic drain_encoder();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_header_ids(input logic [CFG_W-1:0] dev, input logic [CFG_W-1:0] model);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEVICE_ID;
    cfg_wdata <= dev;
    @(posedge clk);
    cfg_index <= CFG_MODEL_ID;
    cfg_wdata <= model;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    midi_cmd_t        directed[$];
    midi_cmd_t        c;
    logic [CFG_W-1:0] dev_ids[NUM_PHASES];
    logic [CFG_W-1:0] model_ids[NUM_PHASES];
    int               send_pcts[NUM_PHASES];
    int               stall_pcts[NUM_PHASES];
    int               pick;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_DEVICE_ID;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_NOTE_OFF;
    in_ch.channel    <= '0;
    in_ch.data_one   <= '0;
    in_ch.data_two   <= '0;
    in_ch.bend_value <= '0;
    in_ch.first      <= 1'b0;
    in_ch.last       <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, reset header ids, no idling
    // sysex tail right after reset: checksum starts from zero
    directed.push_back(mk_cmd(OP_SYSEX,    4'd0,  8'h05, 8'h00, 14'h0000, 1'b0, 1'b1));
    directed.push_back(mk_cmd(OP_NOTE_OFF, 4'd0,  8'h00, 8'h00, 14'h0000, 1'b0, 1'b0));
    // flags on a channel message are ignored
    directed.push_back(mk_cmd(OP_NOTE_ON,  4'd15, 8'hFF, 8'hFF, 14'h3FFF, 1'b1, 1'b1));
    directed.push_back(mk_cmd(OP_CONTROL,  4'd9,  8'h80, 8'h7F, 14'h0000, 1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_PROGRAM,  4'd0,  8'h7F, 8'hFF, 14'h3FFF, 1'b0, 1'b1));
    directed.push_back(mk_cmd(OP_PROGRAM,  4'd15, 8'h80, 8'h00, 14'h0000, 1'b1, 1'b0));
    directed.push_back(mk_cmd(OP_BEND,     4'd3,  8'h00, 8'h00, 14'h0000, 1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_BEND,     4'd12, 8'hFF, 8'hFF, 14'h3FFF, 1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_BEND,     4'd0,  8'h00, 8'h00, 14'h2000, 1'b0, 1'b0));
    // undefined opcodes are swallowed
    directed.push_back(mk_cmd(OP_UNUSED_6, 4'd15, 8'hFF, 8'hFF, 14'h3FFF, 1'b1, 1'b1));
    directed.push_back(mk_cmd(OP_UNUSED_7, 4'd0,  8'h00, 8'h00, 14'h0000, 1'b1, 1'b0));
    // one-byte frame: header, byte, checksum, end
    directed.push_back(mk_cmd(OP_SYSEX,    4'd0,  8'hFF, 8'h00, 14'h0000, 1'b1, 1'b1));
    // multi-byte frame with raw payload above 127
    directed.push_back(mk_cmd(OP_SYSEX,    4'd5,  8'h41, 8'h00, 14'h0000, 1'b1, 1'b0));
    directed.push_back(mk_cmd(OP_SYSEX,    4'd0,  8'h80, 8'h00, 14'h0000, 1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_SYSEX,    4'd0,  8'hFF, 8'h00, 14'h0000, 1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_SYSEX,    4'd0,  8'h00, 8'h00, 14'h0000, 1'b0, 1'b1));
    // frame interleaved with a channel message
    directed.push_back(mk_cmd(OP_SYSEX,    4'd0,  8'h7F, 8'h00, 14'h0000, 1'b1, 1'b0));
    directed.push_back(mk_cmd(OP_NOTE_ON,  4'd1,  8'h3C, 8'h64, 14'h0000, 1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_SYSEX,    4'd0,  8'h01, 8'h00, 14'h0000, 1'b0, 1'b1));
    // tail without header continues the old sum
    directed.push_back(mk_cmd(OP_SYSEX,    4'd0,  8'h10, 8'h00, 14'h0000, 1'b0, 1'b1));
    directed.push_back(mk_cmd(OP_CONTROL,  4'd0,  8'h00, 8'h80, 14'h0000, 1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_BEND,     4'd15, 8'h00, 8'h00, 14'h2AAA, 1'b1, 1'b1));
    foreach (directed[i]) send_cmd(directed[i]);
    drain_encoder();

    // random phases: header ids and idling profile change per phase
    dev_ids    = '{7'd0, 7'd127, CFG_W'($urandom), CFG_W'($urandom)};
    model_ids  = '{7'd0, 7'd127, CFG_W'($urandom), CFG_W'($urandom)};
    send_pcts  = '{0, 51, 0, 7};
    stall_pcts = '{0, 0, 51, 7};
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = stall_pcts[p];
      set_header_ids(dev_ids[p], model_ids[p]);
      cmds_counted = 0;
      while (cmds_counted < PHASE_CMDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_cmd(rand_cmd(OPCODE_W'($urandom_range(int'(OP_NOTE_OFF), int'(OP_BEND)))));
        end else if (pick < 88) begin
          send_sysex_frame($urandom_range(1, 6));
        end else begin
          // noise: any opcode with random flags, broken frames included
          c = rand_cmd(OPCODE_W'($urandom_range(int'(OP_NOTE_OFF), int'(OP_UNUSED_7))));
          send_cmd(c);
        end
      end
      drain_encoder();
    end

    $display("Covered %0d commands and %0d checked bytes, %0d sysex frames closed,",
             cmds_taken, bytes_checked, frames_closed);
    $display("across reset and %0d header id settings and four idling profiles.",
             NUM_PHASES);
    if (fail_count == 0 && bytes_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d expected bytes never arrived",
               fail_count, bytes_pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mme_pkg.sv
src/mme_in_if.sv
src/mme_out_if.sv
src/mme_front.sv
src/mme_queue.sv
src/mme_back.sv
src/midi_message_encoder.sv
sim/mme_stream_checker.sv
sim/tb_midi_message_encoder.sv
